// ----- sv/eman_pkg.sv -----
package eman_pkg;

   localparam int EMAN_ENTRIES = 64;
   localparam int ADDR_W       = 64;
   localparam int ALIGN_W      = 32;

   localparam logic CMD_FREE  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // what every cell of the row does
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_WRITE  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [ADDR_W-1:0]   base;
      logic [ADDR_W-1:0]   len;
   } cell_cmd_type;

   // where a cell stands relative to the addressed slot
   typedef struct packed {
      logic at_pos;
      logic past_pos;
      logic last;
   } cell_sel_type;

endpackage

// ----- sv/eman_cell.sv -----
module eman_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  eman_pkg::cell_cmd_type       cmd,
   input  eman_pkg::cell_sel_type       sel,
   input  logic [eman_pkg::ADDR_W-1:0]  left_base,
   input  logic [eman_pkg::ADDR_W-1:0]  left_len,
   input  logic [eman_pkg::ADDR_W-1:0]  right_base,
   input  logic [eman_pkg::ADDR_W-1:0]  right_len,
   output logic [eman_pkg::ADDR_W-1:0]  base,
   output logic [eman_pkg::ADDR_W-1:0]  len
);
   import eman_pkg::*;

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] len_ff, len_in;

   always_comb begin
      base_in = base_ff;
      len_in  = len_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (sel.at_pos) begin
               base_in = cmd.base;
               len_in  = cmd.len;
            end else if (sel.past_pos && !sel.last) begin
               base_in = left_base;
               len_in  = left_len;
            end
         end
         CELL_REMOVE: begin
            if (sel.at_pos || sel.past_pos) begin
               base_in = sel.last ? '0 : right_base;
               len_in  = sel.last ? '0 : right_len;
            end
         end
         CELL_WRITE: begin
            if (sel.at_pos) begin
               base_in = cmd.base;
               len_in  = cmd.len;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         len_ff  <= '0;
      end else begin
         base_ff <= base_in;
         len_ff  <= len_in;
      end
   end

   assign base = base_ff;
   assign len  = len_ff;

endmodule

// ----- sv/eman_rem.sv -----
module eman_rem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [eman_pkg::ADDR_W-1:0]   dividend,
   input  logic [eman_pkg::ALIGN_W-1:0]  divisor,
   output logic                          done,
   output logic [eman_pkg::ALIGN_W-1:0]  rem
);
   import eman_pkg::*;

   localparam int STEPS = ADDR_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic [ADDR_W-1:0]  q_ff, q_in;
   logic [ALIGN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ALIGN_W:0]   trial;
   logic [ALIGN_W:0]   diff;

   // restoring remainder, one dividend bit a cycle
   assign trial = {rem_ff, q_ff[ADDR_W-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = {q_ff[ADDR_W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? diff[ALIGN_W-1:0] : trial[ALIGN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ----- sv/extent_map_allocator_core.sv -----
// free request: a scan of the extents at or below the base, then the neighbour tests and update
// alloc request: a first-fit walk over the extents, with the remainder unit and the
// round-up when an alignment is given, plus a free pass for the leading gap
// one request at a time, with a single remainder unit and a single read port onto the cell row
// synchronous reset empties every cell at once; no clearing pass
module extent_map_allocator_core #(
   parameter int ENTRIES = eman_pkg::EMAN_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [eman_pkg::ADDR_W-1:0]   req_addr,
   input  logic [eman_pkg::ADDR_W-1:0]   req_size,
   input  logic [eman_pkg::ALIGN_W-1:0]  req_align,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [eman_pkg::ADDR_W-1:0]   rsp_grant_addr,
   output logic                          rsp_lost_extent
);
   import eman_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   // one-hot sequencer states
   typedef enum logic [16:0] {
      ST_IDLE     = 17'h00001,
      ST_F_RD     = 17'h00002,
      ST_F_EV     = 17'h00004,
      ST_F_ACT    = 17'h00008,
      ST_F_UPD    = 17'h00010,
      ST_F_RM     = 17'h00020,
      ST_A_RD     = 17'h00040,
      ST_A_CHK1   = 17'h00080,
      ST_A_CHK2   = 17'h00100,
      ST_A_CHK3   = 17'h00200,
      ST_A_DIV    = 17'h00400,
      ST_A_ALN    = 17'h00800,
      ST_A_OFF1   = 17'h01000,
      ST_A_OFF2   = 17'h02000,
      ST_A_OFF3   = 17'h04000,
      ST_A_COMMIT = 17'h08000,
      ST_DONE     = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // the cell row: one extent per cell, sorted by base
   logic [ADDR_W-1:0] cell_base [ENTRIES];
   logic [ADDR_W-1:0] cell_len  [ENTRIES];
   cell_cmd_type      ccmd;
   logic [IW-1:0]     pos;

   genvar k;
   generate
      for (k = 0; k < ENTRIES; k++) begin : g_cell
         cell_sel_type      sel;
         logic [ADDR_W-1:0] lb, ll, rb, rl;
         assign sel.at_pos   = (pos == IW'(k));
         assign sel.past_pos = (pos < IW'(k));
         assign sel.last     = (k == ENTRIES - 1);
         if (k == 0) begin : g_lo
            assign lb = '0;
            assign ll = '0;
         end else begin : g_mid_lo
            assign lb = cell_base[k-1];
            assign ll = cell_len[k-1];
         end
         if (k == ENTRIES - 1) begin : g_hi
            assign rb = '0;
            assign rl = '0;
         end else begin : g_mid_hi
            assign rb = cell_base[k+1];
            assign rl = cell_len[k+1];
         end
         eman_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (ccmd),
            .sel        (sel),
            .left_base  (lb),
            .left_len   (ll),
            .right_base (rb),
            .right_len  (rl),
            .base       (cell_base[k]),
            .len        (cell_len[k])
         );
      end
   endgenerate

   // read port onto the row, registered
   logic [IW-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0] rd_base_ff, rd_len_ff;

   always_ff @(posedge clock) begin
      rd_base_ff <= cell_base[idx_ff];
      rd_len_ff  <= cell_len[idx_ff];
   end

   // request and working registers
   logic [ADDR_W-1:0]  aa_ff, aa_in;       // alloc required start
   logic [ADDR_W-1:0]  asz_ff, asz_in;     // alloc size
   logic [ALIGN_W-1:0] al_ff, al_in;       // alloc alignment
   logic [ADDR_W-1:0]  fa_ff, fa_in;       // free base
   logic [ADDR_W-1:0]  fs_ff, fs_in;       // free length
   logic [ADDR_W-1:0]  prev_b_ff, prev_b_in;
   logic [ADDR_W-1:0]  prev_l_ff, prev_l_in;
   logic [ADDR_W-1:0]  sum_ff, sum_in;
   logic               mlo_ff, mlo_in;
   logic               mhi_ff, mhi_in;
   logic [ADDR_W-1:0]  d_ff, d_in;         // required start minus base
   logic [ADDR_W-1:0]  ls_ff, ls_in;       // len minus size
   logic               szb_ff, szb_in;     // size above len
   logic [ADDR_W-1:0]  start_ff, start_in;
   logic [ADDR_W-1:0]  off_ff, off_in;
   logic [ADDR_W-1:0]  rem2_ff, rem2_in;
   logic [ADDR_W-1:0]  nl_ff, nl_in;
   logic [ADDR_W-1:0]  grant_ff, grant_in;
   logic               lost_ff, lost_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_grant_ff, rsp_grant_in;
   logic               rsp_lost_ff, rsp_lost_in;

   // remainder unit for the alignment
   logic               div_start;
   logic               div_done;
   logic [ALIGN_W-1:0] div_rem;

   eman_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (start_in),
      .divisor  (al_ff),
      .done     (div_done),
      .rem      (div_rem)
   );

   // datapath pieces
   logic [ADDR_W:0]    chk1_diff;
   logic [ADDR_W:0]    chk2_diff;
   logic [ADDR_W:0]    off3_diff;
   logic [ALIGN_W-1:0] aln_add;
   logic [ADDR_W:0]    aln_sum;
   logic               tail_full;

   assign chk1_diff = {1'b0, aa_ff} - {1'b0, rd_base_ff};
   assign chk2_diff = {1'b0, rd_len_ff} - {1'b0, asz_ff};
   assign off3_diff = {1'b0, rem2_ff} - {1'b0, asz_ff};
   assign aln_add   = al_ff - div_rem;
   assign aln_sum   = {1'b0, start_ff} + {{(ADDR_W + 1 - ALIGN_W){1'b0}}, aln_add};
   // last usable slot occupied: an insert pushes an extent out
   assign tail_full = (cell_len[ENTRIES-2] != '0);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      aa_in        = aa_ff;
      asz_in       = asz_ff;
      al_in        = al_ff;
      fa_in        = fa_ff;
      fs_in        = fs_ff;
      prev_b_in    = prev_b_ff;
      prev_l_in    = prev_l_ff;
      sum_in       = sum_ff;
      mlo_in       = mlo_ff;
      mhi_in       = mhi_ff;
      d_in         = d_ff;
      ls_in        = ls_ff;
      szb_in       = szb_ff;
      start_in     = start_ff;
      off_in       = off_ff;
      rem2_in      = rem2_ff;
      nl_in        = nl_ff;
      grant_in     = grant_ff;
      lost_in      = lost_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_grant_in = rsp_grant_ff;
      rsp_lost_in  = rsp_lost_ff;
      ccmd         = '{op: CELL_HOLD, base: '0, len: '0};
      pos          = idx_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in   = '0;
               grant_in = '0;
               lost_in  = 1'b0;
               if (req_cmd == CMD_ALLOC) begin
                  aa_in    = req_addr;
                  asz_in   = req_size;
                  al_in    = req_align;
                  state_in = ST_A_RD;
               end else begin
                  fa_in    = req_addr;
                  fs_in    = req_size;
                  // a zero-length free leaves the table alone
                  state_in = (req_size == '0) ? ST_DONE : ST_F_RD;
               end
            end
         end

         // ---- free: find the first extent whose base lies above the new one
         ST_F_RD: state_in = ST_F_EV;

         ST_F_EV: begin
            if (idx_ff != LAST_IDX && rd_len_ff != '0 && rd_base_ff <= fa_ff) begin
               prev_b_in = rd_base_ff;
               prev_l_in = rd_len_ff;
               idx_in    = idx_ff + 1'b1;
               state_in  = ST_F_RD;
            end else begin
               state_in = ST_F_ACT;
            end
         end

         // neighbour tests: lower one ends where we start, upper one starts where we end
         ST_F_ACT: begin
            mlo_in   = (idx_ff != '0) && (prev_b_ff + prev_l_ff == fa_ff);
            mhi_in   = (rd_len_ff != '0) && (fa_ff + fs_ff == rd_base_ff);
            sum_in   = prev_l_ff + fs_ff;
            state_in = ST_F_UPD;
         end

         ST_F_UPD: begin
            if (mlo_ff) begin
               pos       = idx_ff - 1'b1;
               ccmd.op   = CELL_WRITE;
               ccmd.base = prev_b_ff;
               ccmd.len  = mhi_ff ? sum_ff + rd_len_ff : sum_ff;
               state_in  = mhi_ff ? ST_F_RM : ST_DONE;
            end else if (mhi_ff) begin
               ccmd.op   = CELL_WRITE;
               ccmd.base = rd_base_ff - fs_ff;
               ccmd.len  = rd_len_ff + fs_ff;
               state_in  = ST_DONE;
            end else if (idx_ff == LAST_IDX) begin
               // table full and the new extent sorts last: it is the one lost
               lost_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               ccmd.op   = CELL_INSERT;
               ccmd.base = fa_ff;
               ccmd.len  = fs_ff;
               if (tail_full) begin
                  lost_in = 1'b1;
               end
               state_in = ST_DONE;
            end
         end

         // both neighbours merged: the upper one goes
         ST_F_RM: begin
            ccmd.op  = CELL_REMOVE;
            state_in = ST_DONE;
         end

         // ---- alloc: first-fit walk
         ST_A_RD: state_in = ST_A_CHK1;

         ST_A_CHK1: begin
            d_in = chk1_diff[ADDR_W-1:0];
            if (idx_ff == LAST_IDX || rd_len_ff == '0) begin
               state_in = ST_DONE;
            end else if (aa_ff == '0) begin
               start_in = rd_base_ff;
               if (al_ff == '0) begin
                  state_in = ST_A_OFF1;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_A_DIV;
               end
            end else if (chk1_diff[ADDR_W]) begin
               // base above the required start: no later extent can hold it
               state_in = ST_DONE;
            end else begin
               state_in = ST_A_CHK2;
            end
         end

         ST_A_CHK2: begin
            if (rd_len_ff < d_ff) begin
               // extent ends below the required start
               idx_in   = idx_ff + 1'b1;
               state_in = ST_A_RD;
            end else begin
               ls_in    = chk2_diff[ADDR_W-1:0];
               szb_in   = chk2_diff[ADDR_W];
               state_in = ST_A_CHK3;
            end
         end

         ST_A_CHK3: begin
            if (szb_ff || d_ff > ls_ff) begin
               state_in = ST_DONE;
            end else begin
               start_in = aa_ff;
               if (al_ff == '0) begin
                  state_in = ST_A_OFF1;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_A_DIV;
               end
            end
         end

         ST_A_DIV: begin
            if (div_done) begin
               state_in = ST_A_ALN;
            end
         end

         // round the start up; an overflow past the top skips the extent
         ST_A_ALN: begin
            if (div_rem == '0) begin
               state_in = ST_A_OFF1;
            end else if (aln_sum[ADDR_W]) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_A_RD;
            end else begin
               start_in = aln_sum[ADDR_W-1:0];
               state_in = ST_A_OFF1;
            end
         end

         ST_A_OFF1: begin
            off_in   = start_ff - rd_base_ff;
            state_in = ST_A_OFF2;
         end

         ST_A_OFF2: begin
            if (off_ff > rd_len_ff) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_A_RD;
            end else begin
               rem2_in  = rd_len_ff - off_ff;
               state_in = ST_A_OFF3;
            end
         end

         ST_A_OFF3: begin
            if (off3_diff[ADDR_W]) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_A_RD;
            end else begin
               nl_in    = off3_diff[ADDR_W-1:0];
               state_in = ST_A_COMMIT;
            end
         end

         // cut the region from the front; an emptied extent leaves the row
         ST_A_COMMIT: begin
            grant_in = start_ff;
            if (nl_ff == '0) begin
               ccmd.op = CELL_REMOVE;
            end else begin
               ccmd.op   = CELL_WRITE;
               ccmd.base = start_ff + asz_ff;
               ccmd.len  = nl_ff;
            end
            if (off_ff != '0) begin
               // hand the leading gap back through the free sequence
               fa_in    = rd_base_ff;
               fs_in    = off_ff;
               idx_in   = '0;
               state_in = ST_F_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_grant_in = grant_ff;
               rsp_lost_in  = lost_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      aa_ff        <= aa_in;
      asz_ff       <= asz_in;
      al_ff        <= al_in;
      fa_ff        <= fa_in;
      fs_ff        <= fs_in;
      prev_b_ff    <= prev_b_in;
      prev_l_ff    <= prev_l_in;
      sum_ff       <= sum_in;
      mlo_ff       <= mlo_in;
      mhi_ff       <= mhi_in;
      d_ff         <= d_in;
      ls_ff        <= ls_in;
      szb_ff       <= szb_in;
      start_ff     <= start_in;
      off_ff       <= off_in;
      rem2_ff      <= rem2_in;
      nl_ff        <= nl_in;
      grant_ff     <= grant_in;
      lost_ff      <= lost_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_lost_ff  <= rsp_lost_in;
   end

   // a new transfer is taken whenever the sequencer is idle, even with a result waiting
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_grant_addr  = rsp_grant_ff;
   assign rsp_lost_extent = rsp_lost_ff;

endmodule
